[rtl/core/fsc_pkg.sv]
package fsc_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int NUM_PLANES        = 6;
  localparam int CFG_REGS          = 8;
  localparam int CFG_IDX_W         = 4;
  localparam int COEF_W            = 33;
  localparam int LEN_W             = 35;
  localparam int CELL_LAT          = 3;

  typedef logic [2:0] plane_idx_t;

  localparam plane_idx_t PL_LEFT   = 3'd0;
  localparam plane_idx_t PL_RIGHT  = 3'd1;
  localparam plane_idx_t PL_BOTTOM = 3'd2;
  localparam plane_idx_t PL_TOP    = 3'd3;
  localparam plane_idx_t PL_NEAR   = 3'd4;
  localparam plane_idx_t PL_FAR    = 3'd5;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] rad;
    logic               vis;
  } beat_t;

  typedef struct packed {
    logic             en;
    plane_idx_t       plane;
    logic [LEN_W-1:0] len;
  } len_wr_t;

  function automatic logic signed [COEF_W-1:0] plane_coef(
    input plane_idx_t         p,
    input logic signed [31:0] m0,
    input logic signed [31:0] m1,
    input logic signed [31:0] m2,
    input logic signed [31:0] m3
  );
    logic signed [COEF_W-1:0] e0, e1, e2, e3, r;
    e0 = COEF_W'(m0);
    e1 = COEF_W'(m1);
    e2 = COEF_W'(m2);
    e3 = COEF_W'(m3);
    case (p)
      PL_LEFT:   r = e0 + e3;
      PL_RIGHT:  r = e3 - e0;
      PL_BOTTOM: r = e1 + e3;
      PL_TOP:    r = e3 - e1;
      PL_NEAR:   r = e2;
      PL_FAR:    r = e3 - e2;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/fsc_cell.sv]
module fsc_cell #(
  parameter int                  FRAC_BITS = fsc_pkg::FRAC_BITS_DEFAULT,
  parameter fsc_pkg::plane_idx_t PLANE     = fsc_pkg::PL_LEFT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_a_in,
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_b_in,
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_c_in,
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_d_in,
  input  fsc_pkg::len_wr_t                   len_wr,
  input  fsc_pkg::beat_t                     beat_in,
  output fsc_pkg::beat_t                     beat_out,
  output logic signed [fsc_pkg::COEF_W-1:0]  coef_a,
  output logic signed [fsc_pkg::COEF_W-1:0]  coef_b,
  output logic signed [fsc_pkg::COEF_W-1:0]  coef_c
);

  localparam int PROD_W = fsc_pkg::COEF_W + 32;
  localparam int LR_W   = fsc_pkg::LEN_W + 1;
  localparam int RL_W   = LR_W + 32;
  localparam int D_W    = fsc_pkg::COEF_W + FRAC_BITS;
  localparam int MAX1   = (PROD_W > RL_W) ? PROD_W : RL_W;
  localparam int ACC_W  = ((MAX1 > D_W) ? MAX1 : D_W) + 3;

  logic signed [fsc_pkg::COEF_W-1:0] cd;
  logic [fsc_pkg::LEN_W-1:0]         len;
  logic signed [LR_W-1:0]            len_eff;
  logic signed [PROD_W-1:0]          p0, p1, p2;
  logic signed [D_W-1:0]             p3;
  logic signed [RL_W-1:0]            p4, q4;
  logic signed [ACC_W-1:0]           s01, s23, total;
  fsc_pkg::beat_t                    b1, b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      cd     <= '0;
      len    <= '0;
    end else begin
      coef_a <= coef_a_in;
      coef_b <= coef_b_in;
      coef_c <= coef_c_in;
      cd     <= coef_d_in;
      if (len_wr.en && (len_wr.plane == PLANE)) begin
        len <= len_wr.len;
      end
    end
  end

  assign len_eff = (len == '0) ? (LR_W'(1) << FRAC_BITS) : {1'b0, len};

  always_ff @(posedge clk) begin
    p0 <= coef_a * beat_in.cx;
    p1 <= coef_b * beat_in.cy;
    p2 <= coef_c * beat_in.cz;
    p3 <= D_W'(cd) <<< FRAC_BITS;
    p4 <= beat_in.rad * len_eff;
    if (rst) begin
      b1.vld <= 1'b0;
    end else begin
      b1 <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    s01 <= ACC_W'(p0) + ACC_W'(p1);
    s23 <= ACC_W'(p2) + ACC_W'(p3);
    q4  <= p4;
    if (rst) begin
      b2.vld <= 1'b0;
    end else begin
      b2 <= b1;
    end
  end

  assign total = s01 + s23 + ACC_W'(q4);

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.vld <= 1'b0;
    end else begin
      beat_out <= '{vld: b2.vld, cx: b2.cx, cy: b2.cy, cz: b2.cz, rad: b2.rad,
                    vis: b2.vis & ~total[ACC_W-1]};
    end
  end

endmodule

[rtl/core/fsc_len_unit.sv]
module fsc_len_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_a [fsc_pkg::NUM_PLANES],
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_b [fsc_pkg::NUM_PLANES],
  input  logic signed [fsc_pkg::COEF_W-1:0]  coef_c [fsc_pkg::NUM_PLANES],
  output logic                               busy,
  output fsc_pkg::len_wr_t                   len_wr
);

  localparam int LW    = fsc_pkg::LEN_W;
  localparam int SQ_W  = 2 * fsc_pkg::COEF_W;
  localparam int RAD_W = 2 * LW;
  localparam int REM_W = LW + 2;
  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(LW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_RND  = 3'd6;

  logic [2:0]                        state;
  fsc_pkg::plane_idx_t               plane;
  logic [CNT_W-1:0]                  cnt;
  logic signed [fsc_pkg::COEF_W-1:0] ca, cb, cc;
  logic [SQ_W-1:0]                   sa, sb, sc;
  logic [RAD_W-1:0]                  rad;
  logic [LW-1:0]                     root;
  logic [REM_W-1:0]                  rem;
  logic [SH_W-1:0]                   rem_sh, trial;
  logic                              fit;

  always_comb begin
    rem_sh = {rem, rad[RAD_W-1 -: 2]};
    trial  = SH_W'({root, 2'b01});
    fit    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plane     <= fsc_pkg::PL_LEFT;
      cnt       <= '0;
      len_wr.en <= 1'b0;
    end else begin
      len_wr.en <= !restart && (state == ST_RND);
      if (restart) begin
        state <= ST_PREP;
        plane <= fsc_pkg::PL_LEFT;
      end else begin
        case (state)
          ST_IDLE: ;
          ST_PREP: state <= ST_SEL;
          ST_SEL:  state <= ST_SQR;
          ST_SQR:  state <= ST_SUM;
          ST_SUM: begin
            cnt   <= CNT_W'(LW - 1);
            state <= ST_ROOT;
          end
          ST_ROOT: begin
            cnt <= cnt - 1'b1;
            if (cnt == '0) begin
              state <= ST_RND;
            end
          end
          ST_RND: begin
            len_wr.plane <= plane;
            len_wr.len   <= root + LW'(REM_W'(root) < rem);
            plane        <= plane + 1'b1;
            state        <= (plane == fsc_pkg::PL_FAR) ? ST_IDLE : ST_SEL;
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SEL: begin
        ca <= coef_a[plane];
        cb <= coef_b[plane];
        cc <= coef_c[plane];
      end
      ST_SQR: begin
        sa <= $unsigned(SQ_W'(ca) * SQ_W'(ca));
        sb <= $unsigned(SQ_W'(cb) * SQ_W'(cb));
        sc <= $unsigned(SQ_W'(cc) * SQ_W'(cc));
      end
      ST_SUM: begin
        rad  <= RAD_W'(sa) + RAD_W'(sb) + RAD_W'(sc);
        root <= '0;
        rem  <= '0;
      end
      ST_ROOT: begin
        rad  <= rad << 2;
        rem  <= fit ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root <= {root[LW-2:0], fit};
      end
      default: ;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/core/frustum_sphere_cull_unit.sv]
// Sphere-against-frustum cull.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..7) and cfg_data; each beat
// loads two Q16.16 matrix entries of one row. Indexes of 8 and above are dropped.
// A valid write starts a recompute of the six plane normal lengths, one square
// root at a time on a shared bit-serial unit; busy stays high until all six roots
// are done, and no sphere is taken meanwhile.
// Spheres: start with center_x/y/z and radius is taken when busy is low, one per
// cycle back to back. Each sphere walks a chain of six plane cells, passing the
// product, sum and result registers of each cell.
// Result: done is high for exactly one cycle with visible; the receiver cannot
// stall, and the chain never holds, so results leave in the order taken.
// Reset clears the matrix and lengths to zero, empties the chain and leaves the
// block idle with busy low.
module frustum_sphere_cull_unit #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               center_x,
  input  logic signed [31:0]               center_y,
  input  logic signed [31:0]               center_z,
  input  logic signed [31:0]               radius,
  output logic                             done,
  output logic                             visible
);

  localparam int NP  = fsc_pkg::NUM_PLANES;
  localparam int LAT = fsc_pkg::CELL_LAT * NP;

  logic signed [31:0]                mat [4][4];
  logic                              cfg_wr;
  logic signed [fsc_pkg::COEF_W-1:0] ca [NP];
  logic signed [fsc_pkg::COEF_W-1:0] cb [NP];
  logic signed [fsc_pkg::COEF_W-1:0] cc [NP];
  fsc_pkg::len_wr_t                  len_wr;
  fsc_pkg::beat_t                    chain [NP+1];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index < fsc_pkg::CFG_IDX_W'(fsc_pkg::CFG_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= '0;
        end
      end
    end else if (cfg_wr) begin
      mat[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[31:0];
      mat[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[63:32];
    end
  end

  fsc_len_unit u_len (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .coef_a  (ca),
    .coef_b  (cb),
    .coef_c  (cc),
    .busy    (busy),
    .len_wr  (len_wr)
  );

  always_comb begin
    chain[0].vld = start && !busy;
    chain[0].cx  = center_x;
    chain[0].cy  = center_y;
    chain[0].cz  = center_z;
    chain[0].rad = radius;
    chain[0].vis = 1'b1;
  end

  for (genvar g = 0; g < NP; g++) begin : g_cell
    localparam fsc_pkg::plane_idx_t PID = fsc_pkg::plane_idx_t'(g);
    fsc_cell #(
      .FRAC_BITS (FRAC_BITS),
      .PLANE     (PID)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef_a_in (fsc_pkg::plane_coef(PID, mat[0][0], mat[0][1], mat[0][2], mat[0][3])),
      .coef_b_in (fsc_pkg::plane_coef(PID, mat[1][0], mat[1][1], mat[1][2], mat[1][3])),
      .coef_c_in (fsc_pkg::plane_coef(PID, mat[2][0], mat[2][1], mat[2][2], mat[2][3])),
      .coef_d_in (fsc_pkg::plane_coef(PID, mat[3][0], mat[3][1], mat[3][2], mat[3][3])),
      .len_wr    (len_wr),
      .beat_in   (chain[g]),
      .beat_out  (chain[g+1]),
      .coef_a    (ca[g]),
      .coef_b    (cb[g]),
      .coef_c    (cc[g])
    );
  end

  assign done    = chain[NP].vld;
  assign visible = chain[NP].vis;

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a sphere taken");

  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("length recompute not started");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !done && !busy)
    else $error("activity right after reset");

  a_len_only_busy: assert property (@(posedge clk) disable iff (rst)
    len_wr.en |-> $past(busy))
    else $error("length written while idle");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC = fsc_pkg::FRAC_BITS_DEFAULT;
  localparam int N_PROBES = 21;
  localparam int N_RAND_PHASES = 10;
  localparam int SPHERES_PER_PHASE = 65;

  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO    = 4'd8;
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI    = 4'd15;

  typedef struct packed {
    logic [2:0]         ph;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] rad;
    logic               known;
    logic               vis;
  } probe_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                   cfg_data = '0;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [31:0]            center_x = '0;
  logic signed [31:0]            center_y = '0;
  logic signed [31:0]            center_z = '0;
  logic signed [31:0]            radius = '0;
  logic                          done;
  logic                          visible;

  logic signed [31:0] cfg_mat [4][4];
  logic signed [32:0] nrm [fsc_pkg::NUM_PLANES][4];
  logic [34:0]        plane_len [fsc_pkg::NUM_PLANES];
  logic [63:0]        regval [fsc_pkg::CFG_REGS];
  logic               vis_q [$];
  logic               want;
  int                 n_bad = 0;

  probe_t probes [0:N_PROBES-1] = '{
    // all-zero matrix: every normal is zero, culled only for negative radius
    '{3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
    '{3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1},
    '{3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0},
    '{3'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{3'd0, 32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'h0001_0000, 1'b1, 1'b1},
    '{3'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
    '{3'd1, 32'h0000_0000, 32'h0000_0000, 32'hFFFB_0000, 32'h0001_0000, 1'b0, 1'b0},
    '{3'd1, 32'h0064_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b0},
    '{3'd1, 32'h0064_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{3'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b0, 1'b0},
    '{3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
    '{3'd2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
    '{3'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
    '{3'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
    '{3'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
    // zero normals with nonzero offsets
    '{3'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
    '{3'd4, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 1'b0, 1'b0},
    '{3'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
    '{3'd4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}
  };

  frustum_sphere_cull_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .done      (done),
    .visible   (visible)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [34:0] isqrt_round(input logic [127:0] s);
    logic [127:0] r, t, rem;
    int b;
    r = '0;
    for (b = 34; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    rem = s - r * r;
    if (rem > r) r = r + 128'd1;
    return r[34:0];
  endfunction

  function automatic void derive_planes();
    logic signed [32:0]  e0, e1, e2, e3;
    logic signed [127:0] a, s;
    int j, p, k;
    for (j = 0; j < 4; j++) begin
      e0 = cfg_mat[j][0];
      e1 = cfg_mat[j][1];
      e2 = cfg_mat[j][2];
      e3 = cfg_mat[j][3];
      nrm[fsc_pkg::PL_LEFT][j]   = e0 + e3;
      nrm[fsc_pkg::PL_RIGHT][j]  = e3 - e0;
      nrm[fsc_pkg::PL_BOTTOM][j] = e1 + e3;
      nrm[fsc_pkg::PL_TOP][j]    = e3 - e1;
      nrm[fsc_pkg::PL_NEAR][j]   = e2;
      nrm[fsc_pkg::PL_FAR][j]    = e3 - e2;
    end
    for (p = 0; p < fsc_pkg::NUM_PLANES; p++) begin
      s = '0;
      for (k = 0; k < 3; k++) begin
        a = nrm[p][k];
        s = s + a * a;
      end
      plane_len[p] = isqrt_round(s);
    end
  endfunction

  function automatic logic sphere_visible(input logic signed [31:0] cx, cy, cz, rad);
    logic signed [127:0] acc, k, v, ln;
    logic vis;
    int p;
    vis = 1'b1;
    for (p = 0; p < fsc_pkg::NUM_PLANES; p++) begin
      if (plane_len[p] == '0) ln = 128'sd1 <<< FRAC;
      else ln = {93'd0, plane_len[p]};
      k = nrm[p][0]; v = cx;  acc = k * v;
      k = nrm[p][1]; v = cy;  acc = acc + k * v;
      k = nrm[p][2]; v = cz;  acc = acc + k * v;
      k = nrm[p][3];          acc = acc + (k <<< FRAC);
      v = rad;                acc = acc + v * ln;
      if (acc < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic logic [31:0] rand_entry(input bit wild);
    if (wild) begin
      case ($urandom_range(0, 9))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3, 4:    return $urandom();
        default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
    end
    if ($urandom_range(0, 9) == 0) return 32'h0000_0000;
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [31:0] rand_radius();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, 32'h0005_0000) - 32'h0000_8000;
  endfunction

  task automatic write_reg(input logic [fsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data, input int gap);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx <= REG_ROW3_COLS23) begin
      cfg_mat[idx >> 1][(idx & 1) * 2]     = data[31:0];
      cfg_mat[idx >> 1][(idx & 1) * 2 + 1] = data[63:32];
      derive_planes();
    end
  endtask

  task automatic write_matrix(input bit shuffle, input bit spare);
    int ord [fsc_pkg::CFG_REGS];
    int i, j, tmp;
    for (i = 0; i < fsc_pkg::CFG_REGS; i++) ord[i] = i;
    if (shuffle) begin
      for (i = 0; i < fsc_pkg::CFG_REGS; i++) begin
        j = $urandom_range(0, fsc_pkg::CFG_REGS - 1);
        tmp = ord[i];
        ord[i] = ord[j];
        ord[j] = tmp;
      end
    end
    for (i = 0; i < fsc_pkg::CFG_REGS; i++)
      write_reg(ord[i][fsc_pkg::CFG_IDX_W-1:0], regval[ord[i]],
                shuffle ? $urandom_range(0, 4) : 0);
    if (spare) begin
      write_reg(REG_SPARE_LO, {$urandom(), $urandom()}, 0);
      write_reg(REG_SPARE_HI, {$urandom(), $urandom()}, 0);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_directed_matrix(input int ph);
    int i;
    for (i = 0; i < fsc_pkg::CFG_REGS; i++) regval[i] = '0;
    case (ph)
      1: begin
        regval[REG_ROW0_COLS01] = {32'h0000_0000, 32'h0001_0000};
        regval[REG_ROW1_COLS01] = {32'h0001_0000, 32'h0000_0000};
        regval[REG_ROW2_COLS23] = {32'h0001_0000, 32'h0001_0000};
        regval[REG_ROW3_COLS23] = {32'h0000_0000, 32'hFFFF_8000};
      end
      2: for (i = 0; i < fsc_pkg::CFG_REGS; i++) regval[i] = 64'h7FFF_FFFF_7FFF_FFFF;
      3: for (i = 0; i < fsc_pkg::CFG_REGS; i++) regval[i] = 64'h8000_0000_8000_0000;
      4: begin
        regval[REG_ROW3_COLS01] = {32'h0003_0000, 32'hFFFE_0000};
        regval[REG_ROW3_COLS23] = {32'h0001_0000, 32'h0000_8000};
      end
      default: ;
    endcase
  endtask

  task automatic send_sphere(input logic signed [31:0] cx, cy, cz, rad, input int gap,
                             input logic known, input logic vis);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    radius   <= rad;
    do @(posedge clk); while (busy !== 1'b0);
    vis_q.push_back(known ? vis : sphere_visible(cx, cy, cz, rad));
  endtask

  // caller lowers start first; always advances at least one edge
  task automatic drain();
    do @(posedge clk); while (vis_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (vis_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat: visible=%b", visible);
      end else begin
        want = vis_q.pop_front();
        if (visible !== want) begin
          n_bad++;
          if (n_bad <= 10) $display("visible mismatch: want %b got %b", want, visible);
        end
      end
    end
  end

  initial begin
    int cur, i, ph, n, gap;
    for (i = 0; i < 16; i++) cfg_mat[i / 4][i % 4] = '0;
    derive_planes();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    cur = 0;
    for (i = 0; i < N_PROBES; i++) begin
      if (probes[i].ph != cur) begin
        start <= 1'b0;
        drain();
        cur = probes[i].ph;
        set_directed_matrix(cur);
        write_matrix(1'b0, cur == 4);
      end
      send_sphere(probes[i].cx, probes[i].cy, probes[i].cz, probes[i].rad, 0,
                  probes[i].known, probes[i].vis);
    end

    for (ph = 0; ph < N_RAND_PHASES; ph++) begin
      start <= 1'b0;
      drain();
      for (i = 0; i < fsc_pkg::CFG_REGS; i++)
        regval[i] = {rand_entry(ph % 4 == 3), rand_entry(ph % 4 == 3)};
      write_matrix(1'b1, $urandom_range(0, 3) == 0);
      for (n = 0; n < SPHERES_PER_PHASE; n++) begin
        if ((ph == 4 && n == 32) || $urandom_range(0, 63) == 0) begin
          start <= 1'b0;
          drain();
        end
        gap = (ph % 3 == 0) ? 0 : $urandom_range(0, 4);
        send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius(), gap,
                    1'b0, 1'b0);
      end
    end

    start <= 1'b0;
    drain();
    repeat (25) @(posedge clk);
    if (n_bad == 0 && vis_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/fsc_pkg.sv
rtl/core/fsc_cell.sv
rtl/core/fsc_len_unit.sv
rtl/core/frustum_sphere_cull_unit.sv
tb/testbench.sv
